[rtl/multicast_ring_slot_manager_top_macros.svh]
// Assertion macros used by the checker file
`ifndef MULTICAST_RING_SLOT_MANAGER_TOP_MACROS_SVH
`define MULTICAST_RING_SLOT_MANAGER_TOP_MACROS_SVH
// Check that a condition implies a consequence in the same cycle
`define MRSM_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle
`define MRSM_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/mrsm_pkg.sv]
// Shared types and codes of the multicast ring slot manager
package mrsm_pkg;
    localparam logic [2:0] OP_OPEN  = 3'd0;
    localparam logic [2:0] OP_CLOSE = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_POLL  = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BLOCK   = 3'd1;
    localparam logic [2:0] ST_NO_BIT  = 3'd2;
    localparam logic [2:0] ST_BAD_LEN = 3'd3;
    localparam logic [2:0] ST_OFFLINE = 3'd4;

    localparam logic CFG_MAX_LEN = 1'b0;
    localparam logic CFG_SLOTS   = 1'b1;

    // Result item as it travels to the output register
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  assigned_reader;
        logic [5:0]  slot_index;
        logic [15:0] length_out;
        logic        readable;
        logic        hung_up;
        logic        slot_freed;
    } result_t;
endpackage

[rtl/mrsm_out_reg.sv]
// Output register stage of the result channel
module mrsm_out_reg
    import mrsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    input  logic    take,
    output logic    full,
    output result_t res_out
);
    logic full_reg;
    result_t res_reg;

    // Hold a result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (load)
        begin
            full_reg <= 1'b1;
        end
        else if (take)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign full = full_reg;
    assign res_out = res_reg;
endmodule

[rtl/multicast_ring_slot_manager_top.sv]
// Top level of the multicast ring slot manager
//
// Control block of a one-writer, many-reader ring. One input channel takes
// commands (open, close, write, read, poll) with valid/ready; one output
// channel returns one result item per command with valid/ready. A plain
// write port sets max_message_length (index 0) and slots_in_use (index 1).
//
// An item's result is formed in steps: the read pointer is read at the
// accepting edge, then the slot's pending set and length, then the update
// is written back and the result is registered; it then moves to the output
// register once that is free or being emptied. The next item is taken only
// after that move. A close of a valid reader, and a write that evicts laggards,
// sweep all SLOTS pending entries, each through a read and a write state.
// While the receiver stalls, one more item is accepted and its result waits
// behind the output register; then the input holds off.
//
// Reset clears the reader mask, write pointer and online bits, then runs a
// clearing pass over every entry of the pending memory before the first
// item is accepted. Configuration writes take effect at once; make them only
// while no item is in flight.
module multicast_ring_slot_manager_top
    import mrsm_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int READERS = 64,
    parameter int LENGTH_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [5:0]  reader_id,
    input  logic [15:0] byte_count,
    input  logic        give_up,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [5:0]  assigned_reader,
    output logic [5:0]  slot_index,
    output logic [15:0] length_out,
    output logic        readable,
    output logic        hung_up,
    output logic        slot_freed
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = SW + 1;
    localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int LW = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_EXEC, S_SWEEP_RD,
                              S_SWEEP_WR, S_DONE} state_t;

    state_t state_reg;
    logic [15:0] max_len_reg;
    logic [6:0]  slots_cfg_reg;
    logic [READERS-1:0] mask_reg;
    logic [SW-1:0] wp_reg;
    logic [READERS-1:0] online_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0]  op_reg;
    logic [5:0]  rid_reg;
    logic [15:0] bc_reg;
    logic        gu_reg;
    logic [READERS-1:0] drop_reg;
    logic [SW-1:0] slot_reg;
    result_t res_reg;
    result_t res_next;
    logic load;
    logic res_move;
    logic full;
    result_t res_q;

    // Slot memories
    logic [READERS-1:0] pend_mem [SLOTS];
    logic [15:0] len_mem [SLOTS];
    logic [READERS-1:0] pend_rd;
    logic [15:0] len_rd;
    logic [SW-1:0] rd_addr;
    logic pend_we;
    logic [SW-1:0] pend_wa;
    logic [READERS-1:0] pend_wd;
    logic len_we;

    // Read pointer memory
    logic [SW-1:0] rp_mem [READERS];
    logic [SW-1:0] rp_rd;
    logic [RW-1:0] rp_ra;
    logic rp_we;
    logic [RW-1:0] rp_wa;
    logic [SW-1:0] rp_wd;

    always_ff @(posedge clk)
    begin
        pend_rd <= pend_mem[rd_addr];
        len_rd <= len_mem[rd_addr];
        if (pend_we)
        begin
            pend_mem[pend_wa] <= pend_wd;
        end
        if (len_we)
        begin
            len_mem[pend_wa] <= bc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_rd <= rp_mem[rp_ra];
        if (rp_we)
        begin
            rp_mem[rp_wa] <= rp_wd;
        end
    end

    // Ring size and pointer helpers
    logic [CW-1:0] ring;
    always_comb
    begin
        if (slots_cfg_reg == 7'd0)
        begin
            ring = CW'(1);
        end
        else if ({25'd0, slots_cfg_reg} > 32'(SLOTS))
        begin
            ring = CW'(SLOTS);
        end
        else
        begin
            ring = CW'(slots_cfg_reg);
        end
    end

    function automatic logic [SW-1:0] eff(input logic [SW-1:0] p, input logic [CW-1:0] n);
        eff = ({1'b0, p} < n) ? p : '0;
    endfunction

    function automatic logic [SW-1:0] nxt(input logic [SW-1:0] p, input logic [CW-1:0] n);
        logic [CW-1:0] q;
        q = {1'b0, eff(p, n)} + CW'(1);
        nxt = (q >= n) ? '0 : q[SW-1:0];
    endfunction

    // Lowest free reader bit
    logic [READERS-1:0] freebits;
    logic [RW-1:0] free_idx;
    always_comb
    begin
        freebits = ~mask_reg;
        free_idx = '0;
        for (int i = READERS - 1; i >= 0; i--)
        begin
            if (freebits[i])
            begin
                free_idx = RW'(i);
            end
        end
    end

    logic valid_id;
    logic [RW-1:0] rid_n;
    logic [READERS-1:0] bit_r;
    logic len_bad;
    assign valid_id = {26'd0, rid_reg} < 32'(READERS);
    assign rid_n = rid_reg[RW-1:0];
    assign bit_r = valid_id ? (READERS'(1) << rid_n) : '0;
    assign len_bad = (bc_reg == 16'd0) || (bc_reg > max_len_reg) ||
                     ((LW < 16) && ((bc_reg >> LW) != 16'd0));

    // Read the pointer of the arriving reader at the accepting edge
    assign rp_ra = (state_reg == S_IDLE) ? reader_id[RW-1:0] : rid_n;

    // Memory read address
    always_comb
    begin
        if (state_reg == S_CLEAR || state_reg == S_SWEEP_RD || state_reg == S_SWEEP_WR)
        begin
            rd_addr = cnt_reg[SW-1:0];
        end
        else if (op_reg == OP_WRITE)
        begin
            rd_addr = eff(wp_reg, ring);
        end
        else
        begin
            rd_addr = eff(rp_rd, ring);
        end
    end

    // Read pointer updates on open and on a successful read
    always_comb
    begin
        rp_we = 1'b0;
        rp_wa = rid_n;
        rp_wd = nxt(rd_addr, ring);
        if (state_reg == S_EXEC && op_reg == OP_OPEN && freebits != '0)
        begin
            rp_we = 1'b1;
            rp_wa = free_idx;
            rp_wd = eff(wp_reg, ring);
        end
        else if (state_reg == S_EXEC && op_reg == OP_READ && valid_id &&
                 online_reg[rid_n] && ((pend_rd & bit_r) != '0))
        begin
            rp_we = 1'b1;
        end
    end

    // Memory writes and result forming
    always_comb
    begin
        pend_we = 1'b0;
        len_we = 1'b0;
        pend_wa = slot_reg;
        pend_wd = '0;
        res_next = '0;
        if (state_reg == S_CLEAR)
        begin
            pend_we = 1'b1;
            pend_wa = cnt_reg[SW-1:0];
        end
        else if (state_reg == S_SWEEP_WR)
        begin
            pend_we = 1'b1;
            pend_wa = cnt_reg[SW-1:0];
            pend_wd = pend_rd & ~drop_reg;
        end
        else if (state_reg == S_EXEC && op_reg == OP_WRITE && !len_bad &&
                 (pend_rd == '0 || gu_reg))
        begin
            pend_we = (pend_rd == '0);
            len_we = pend_we;
            pend_wa = rd_addr;
            pend_wd = mask_reg;
        end
        else if (state_reg == S_DONE)
        begin
            pend_we = 1'b1;
            len_we = 1'b1;
            pend_wa = slot_reg;
            pend_wd = mask_reg;
        end
        else if (state_reg == S_EXEC && op_reg == OP_READ && valid_id &&
                 online_reg[rid_n] && ((pend_rd & bit_r) != '0))
        begin
            pend_we = 1'b1;
            pend_wa = rd_addr;
            pend_wd = pend_rd & ~bit_r;
        end
    end

    logic [15:0] clip;
    assign clip = (len_rd < bc_reg) ? len_rd : bc_reg;

    // Move a waiting result once the output register is free or being emptied
    assign res_move = load && (!full || out_ready);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg <= '0;
            max_len_reg <= 16'd1024;
            slots_cfg_reg <= 7'd64;
            mask_reg <= '0;
            wp_reg <= '0;
            online_reg <= '0;
            load <= 1'b0;
        end
        else
        begin
            if (res_move)
            begin
                load <= 1'b0;
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_MAX_LEN)
                begin
                    max_len_reg <= cfg_data;
                end
                else
                begin
                    slots_cfg_reg <= cfg_data[6:0];
                end
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (cnt_reg == CW'(SLOTS - 1))
                    begin
                        state_reg <= S_IDLE;
                        cnt_reg <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        op_reg <= opcode;
                        rid_reg <= reader_id;
                        bc_reg <= byte_count;
                        gu_reg <= give_up;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    res_reg <= '0;
                    state_reg <= S_IDLE;
                    load <= 1'b1;
                    case (op_reg)
                        OP_OPEN:
                        begin
                            if (freebits == '0)
                            begin
                                res_reg.status <= ST_NO_BIT;
                            end
                            else
                            begin
                                mask_reg[free_idx] <= 1'b1;
                                online_reg[free_idx] <= 1'b1;
                                res_reg.assigned_reader <= 6'(free_idx);
                            end
                        end
                        OP_CLOSE:
                        begin
                            if (valid_id)
                            begin
                                drop_reg <= bit_r;
                                mask_reg <= mask_reg & ~bit_r;
                                online_reg[rid_n] <= 1'b0;
                                cnt_reg <= '0;
                                load <= 1'b0;
                                state_reg <= S_SWEEP_RD;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (len_bad)
                            begin
                                res_reg.status <= ST_BAD_LEN;
                            end
                            else if (pend_rd != '0 && !gu_reg)
                            begin
                                res_reg.status <= ST_BLOCK;
                            end
                            else
                            begin
                                slot_reg <= rd_addr;
                                wp_reg <= nxt(rd_addr, ring);
                                res_reg.slot_index <= 6'(rd_addr);
                                res_reg.length_out <= bc_reg;
                                if (pend_rd != '0)
                                begin
                                    drop_reg <= pend_rd;
                                    mask_reg <= mask_reg & ~pend_rd;
                                    online_reg <= online_reg & ~pend_rd;
                                    cnt_reg <= '0;
                                    load <= 1'b0;
                                    state_reg <= S_SWEEP_RD;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            if (!valid_id || !online_reg[rid_n])
                            begin
                                res_reg.status <= ST_OFFLINE;
                            end
                            else if ((pend_rd & bit_r) == '0)
                            begin
                                res_reg.status <= ST_BLOCK;
                            end
                            else
                            begin
                                res_reg.slot_index <= 6'(rd_addr);
                                res_reg.length_out <= clip;
                                res_reg.slot_freed <= ((pend_rd & ~bit_r) == '0);
                            end
                        end
                        OP_POLL:
                        begin
                            if (!valid_id || !online_reg[rid_n])
                            begin
                                res_reg.hung_up <= 1'b1;
                            end
                            else
                            begin
                                res_reg.readable <= ((pend_rd & bit_r) != '0);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SWEEP_RD:
                begin
                    state_reg <= S_SWEEP_WR;
                end
                S_SWEEP_WR:
                begin
                    if (cnt_reg == CW'(SLOTS - 1))
                    begin
                        if (op_reg == OP_WRITE)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            load <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                        state_reg <= S_SWEEP_RD;
                    end
                end
                S_DONE:
                begin
                    load <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result register and output stage
    mrsm_out_reg u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (res_move),
        .res_in  (res_reg),
        .take    (out_ready),
        .full    (full),
        .res_out (res_q)
    );

    assign in_ready = (state_reg == S_IDLE) && !load;
    assign out_valid = full;
    assign status = res_q.status;
    assign assigned_reader = res_q.assigned_reader;
    assign slot_index = res_q.slot_index;
    assign length_out = res_q.length_out;
    assign readable = res_q.readable;
    assign hung_up = res_q.hung_up;
    assign slot_freed = res_q.slot_freed;
endmodule

[rtl/mrsm_checker.sv]
// Port-level checker of the multicast ring slot manager and its binding
`include "multicast_ring_slot_manager_top_macros.svh"
module mrsm_checker
    import mrsm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic       hung_up,
    input logic       readable,
    input logic [15:0] length_out
);
    `MRSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status))
    `MRSM_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
    `MRSM_ASSERT_SAME(a_status_range, clk, rst_n, out_valid, status <= ST_OFFLINE)
    `MRSM_ASSERT_SAME(a_poll_flags, clk, rst_n, out_valid, !(hung_up && readable))
    `MRSM_ASSERT_SAME(a_fail_no_len, clk, rst_n, out_valid && status != ST_OK, length_out == 16'd0)
endmodule

bind multicast_ring_slot_manager_top mrsm_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .hung_up    (hung_up),
    .readable   (readable),
    .length_out (length_out)
);

[tb/sv/tb_multicast_ring_slot_manager_top.sv]
// Testbench for the multicast ring slot manager: directed and random commands checked against a ring predictor
`timescale 1ns / 100ps

// Ring state mirror; predicts one result per accepted command and checks results in order
class ring_scoreboard;
    logic [15:0] max_len;
    logic [6:0]  slots_cfg;
    logic [63:0] reader_mask;
    int unsigned wr_ptr;
    logic [63:0] pending [64];
    logic [15:0] slot_len [64];
    int unsigned rd_ptr [64];
    bit          online [64];
    mrsm_pkg::result_t expected_results [$];
    int          errors;

    function new();
        max_len     = 16'd1024;
        slots_cfg   = 7'd64;
        reader_mask = '0;
        wr_ptr      = 0;
        errors      = 0;
        for (int i = 0; i < 64; i++)
        begin
            pending[i]  = '0;
            slot_len[i] = '0;
            rd_ptr[i]   = 0;
            online[i]   = 1'b0;
        end
    endfunction

    function void set_reg(logic idx, logic [15:0] value);
        if (idx == mrsm_pkg::CFG_MAX_LEN)
            max_len = value;
        else
            slots_cfg = value[6:0];
    endfunction

    function int unsigned ring_len();
        if (slots_cfg == 0)
            return 1;
        if (slots_cfg > 64)
            return 64;
        return slots_cfg;
    endfunction

    function int unsigned wrap_ptr(int unsigned p);
        return (p < ring_len()) ? p : 0;
    endfunction

    function int unsigned step_ptr(int unsigned p);
        int unsigned q;
        q = wrap_ptr(p) + 1;
        return (q >= ring_len()) ? 0 : q;
    endfunction

    // Remove readers from the mask and from every slot
    function void strip_readers(logic [63:0] bits);
        reader_mask &= ~bits;
        for (int i = 0; i < 64; i++)
            pending[i] &= ~bits;
    endfunction

    function int online_count();
        int n;
        n = 0;
        for (int i = 0; i < 64; i++)
            n += online[i];
        return n;
    endfunction

    // Apply one accepted command and queue its expected result
    function void note_command(logic [2:0] op, logic [5:0] rid, logic [15:0] cnt, logic gu);
        mrsm_pkg::result_t r;
        logic [63:0] bit_sel;
        logic [63:0] evict;
        int unsigned s;
        r = '0;
        bit_sel = 64'd1 << rid;
        case (op)
            mrsm_pkg::OP_OPEN:
            begin
                if (&reader_mask)
                    r.status = mrsm_pkg::ST_NO_BIT;
                else
                begin
                    for (int i = 0; i < 64; i++)
                    begin
                        if (!reader_mask[i])
                        begin
                            reader_mask[i] = 1'b1;
                            rd_ptr[i] = wrap_ptr(wr_ptr);
                            online[i] = 1'b1;
                            r.assigned_reader = i[5:0];
                            break;
                        end
                    end
                end
            end
            mrsm_pkg::OP_CLOSE:
            begin
                strip_readers(bit_sel);
                online[rid] = 1'b0;
            end
            mrsm_pkg::OP_WRITE:
            begin
                if (cnt == 0 || cnt > max_len)
                    r.status = mrsm_pkg::ST_BAD_LEN;
                else
                begin
                    s = wrap_ptr(wr_ptr);
                    if (pending[s] != 0 && !gu)
                        r.status = mrsm_pkg::ST_BLOCK;
                    else
                    begin
                        evict = pending[s];
                        if (evict != 0)
                        begin
                            strip_readers(evict);
                            for (int i = 0; i < 64; i++)
                                if (evict[i])
                                    online[i] = 1'b0;
                        end
                        slot_len[s] = cnt;
                        pending[s]  = reader_mask;
                        wr_ptr      = step_ptr(s);
                        r.slot_index = s[5:0];
                        r.length_out = cnt;
                    end
                end
            end
            mrsm_pkg::OP_READ:
            begin
                if (!online[rid])
                    r.status = mrsm_pkg::ST_OFFLINE;
                else
                begin
                    s = wrap_ptr(rd_ptr[rid]);
                    if ((pending[s] & bit_sel) == 0)
                        r.status = mrsm_pkg::ST_BLOCK;
                    else
                    begin
                        pending[s] &= ~bit_sel;
                        r.length_out = (slot_len[s] < cnt) ? slot_len[s] : cnt;
                        r.slot_freed = (pending[s] == 0);
                        rd_ptr[rid]  = step_ptr(s);
                        r.slot_index = s[5:0];
                    end
                end
            end
            mrsm_pkg::OP_POLL:
            begin
                if (!online[rid])
                    r.hung_up = 1'b1;
                else
                begin
                    s = wrap_ptr(rd_ptr[rid]);
                    r.readable = ((pending[s] & bit_sel) != 0);
                end
            end
            default: ;
        endcase
        expected_results.push_back(r);
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(mrsm_pkg::result_t got);
        mrsm_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result with no command outstanding");
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status)
        begin
            $error("status expected %0d got %0d", want.status, got.status);
            errors++;
        end
        if (got.assigned_reader !== want.assigned_reader)
        begin
            $error("assigned_reader expected %0d got %0d",
                   want.assigned_reader, got.assigned_reader);
            errors++;
        end
        if (got.slot_index !== want.slot_index)
        begin
            $error("slot_index expected %0d got %0d", want.slot_index, got.slot_index);
            errors++;
        end
        if (got.length_out !== want.length_out)
        begin
            $error("length_out expected %0d got %0d", want.length_out, got.length_out);
            errors++;
        end
        if (got.readable !== want.readable)
        begin
            $error("readable expected %0d got %0d", want.readable, got.readable);
            errors++;
        end
        if (got.hung_up !== want.hung_up)
        begin
            $error("hung_up expected %0d got %0d", want.hung_up, got.hung_up);
            errors++;
        end
        if (got.slot_freed !== want.slot_freed)
        begin
            $error("slot_freed expected %0d got %0d", want.slot_freed, got.slot_freed);
            errors++;
        end
    endfunction
endclass

module tb_multicast_ring_slot_manager_top;
    import mrsm_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 80;
    localparam int ITEMS_PER_PHASE = 210;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  opcode = '0;
    logic [5:0]  reader_id = '0;
    logic [15:0] byte_count = '0;
    logic        give_up = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [5:0]  assigned_reader;
    logic [5:0]  slot_index;
    logic [15:0] length_out;
    logic        readable;
    logic        hung_up;
    logic        slot_freed;

    ring_scoreboard ring_sb = new();
    int send_idle_pct = 10;
    int recv_idle_pct = 61;
    bit hold_request = 1'b0;
    int quiet_cycles = 0;

    multicast_ring_slot_manager_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .reader_id(reader_id), .byte_count(byte_count), .give_up(give_up),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .assigned_reader(assigned_reader), .slot_index(slot_index),
        .length_out(length_out), .readable(readable), .hung_up(hung_up),
        .slot_freed(slot_freed)
    );

    always #4 clk = ~clk;

    // Receiver: random stalls, or one long hold-off on request
    always
    begin
        @(posedge clk);
        if (hold_request)
        begin
            out_ready <= 1'b0;
            repeat (300) @(posedge clk);
            hold_request = 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every result taken by the receiver
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            ring_sb.check_result({status, assigned_reader, slot_index, length_out,
                                  readable, hung_up, slot_freed});
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one command and hold it until accepted
    task automatic send_cmd(logic [2:0] op, logic [5:0] rid, logic [15:0] cnt, logic gu);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        reader_id  <= rid;
        byte_count <= cnt;
        give_up    <= gu;
        do
            @(posedge clk);
        while (!in_ready);
        ring_sb.note_command(op, rid, cnt, gu);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        while (ring_sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        ring_sb.set_reg(idx, value);
    endtask

    function automatic logic [5:0] pick_reader();
        int start;
        start = $urandom_range(63);
        for (int i = 0; i < 64; i++)
            if (ring_sb.online[(start + i) % 64])
                return 6'((start + i) % 64);
        return 6'(start);
    endfunction

    // One random command, mostly well-formed traffic on online readers
    task automatic random_cmd();
        int roll;
        int cap;
        logic [15:0] cnt;
        roll = $urandom_range(99);
        cap = (ring_sb.max_len < 64) ? ring_sb.max_len : 64;
        if (cap == 0)
            cap = 1;
        if (roll < 8 && ring_sb.online_count() < 10)
            send_cmd(OP_OPEN, 6'($urandom), 16'($urandom), 1'($urandom));
        else if (roll < 12)
            send_cmd(OP_CLOSE, ($urandom_range(3) == 0) ? 6'($urandom) : pick_reader(),
                     16'($urandom), 1'($urandom));
        else if (roll < 45)
        begin
            case ($urandom_range(9))
                0: cnt = 16'd0;
                1: cnt = ring_sb.max_len;
                2: cnt = ring_sb.max_len + 16'd1;
                3: cnt = 16'($urandom);
                default: cnt = 16'($urandom_range(cap, 1));
            endcase
            send_cmd(OP_WRITE, 6'($urandom), cnt, ($urandom_range(3) == 0));
        end
        else if (roll < 80)
            send_cmd(OP_READ, ($urandom_range(9) == 0) ? 6'($urandom) : pick_reader(),
                     ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(64)),
                     1'($urandom));
        else if (roll < 93)
            send_cmd(OP_POLL, ($urandom_range(4) == 0) ? 6'($urandom) : pick_reader(),
                     16'($urandom), 1'($urandom));
        else
            send_cmd(3'($urandom_range(7, 5)), 6'($urandom), 16'($urandom), 1'($urandom));
    endtask

    initial
    begin
        logic [15:0] max_values [7];
        logic [15:0] slot_values [7];
        max_values  = '{16'd1024, 16'd65535, 16'd1, 16'd300, 16'd40, 16'd2000, 16'd64};
        slot_values = '{16'd64, 16'd4, 16'd1, 16'd0, 16'd127, 16'd2, 16'd3};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase == 3)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 10;
            end
            else if (phase == 5)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase != 0)
                go_idle();
            write_reg(CFG_MAX_LEN, max_values[phase]);
            write_reg(CFG_SLOTS, slot_values[phase]);

            // Directed: offline readers, bad lengths, clipping, freeing, odd opcodes
            if (phase == 0)
            begin
                send_cmd(OP_POLL, 6'd0, 16'd0, 1'b0);
                send_cmd(OP_READ, 6'd63, 16'hFFFF, 1'b1);
                send_cmd(OP_WRITE, 6'd0, 16'd0, 1'b0);
                send_cmd(OP_WRITE, 6'd0, 16'd1025, 1'b0);
                send_cmd(OP_WRITE, 6'd63, 16'hFFFF, 1'b1);
                send_cmd(OP_OPEN, 6'd0, 16'd0, 1'b0);
                send_cmd(OP_OPEN, 6'd63, 16'hFFFF, 1'b1);
                send_cmd(OP_WRITE, 6'd0, 16'd1024, 1'b0);
                send_cmd(OP_POLL, 6'd0, 16'd0, 1'b0);
                send_cmd(OP_READ, 6'd0, 16'd10, 1'b0);
                send_cmd(OP_READ, 6'd0, 16'd10, 1'b0);
                send_cmd(OP_POLL, 6'd1, 16'd0, 1'b0);
                send_cmd(OP_READ, 6'd1, 16'hFFFF, 1'b0);
                send_cmd(OP_WRITE, 6'd0, 16'd1, 1'b1);
                send_cmd(OP_CLOSE, 6'd0, 16'd0, 1'b0);
                send_cmd(OP_POLL, 6'd0, 16'd0, 1'b0);
                send_cmd(OP_READ, 6'd0, 16'd5, 1'b0);
                send_cmd(OP_CLOSE, 6'd63, 16'hFFFF, 1'b1);
                send_cmd(3'd5, 6'd21, 16'h5555, 1'b0);
                send_cmd(3'd7, 6'd42, 16'hAAAA, 1'b1);
                send_cmd(3'd6, 6'd63, 16'hFFFF, 1'b1);
            end

            // Receiver holds off while commands keep coming
            if (phase == 1)
                hold_request = 1'b1;

            // Fill every reader bit, try more opens, then release them all
            if (phase == 2)
            begin
                for (int i = 0; i < 66; i++)
                    send_cmd(OP_OPEN, 6'($urandom), 16'($urandom), 1'($urandom));
                send_cmd(OP_WRITE, 6'd0, 16'd1, 1'b0);
                send_cmd(OP_WRITE, 6'd0, 16'd1, 1'b0);
                send_cmd(OP_WRITE, 6'd0, 16'd1, 1'b1);
                for (int i = 0; i < 64; i++)
                    send_cmd(OP_CLOSE, i[5:0], 16'($urandom), 1'($urandom));
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                random_cmd();
        end

        in_valid <= 1'b0;
        while (ring_sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (ring_sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
